FILE: rtl/bptc_pkg.sv
// Shared constants, register codes and 32-bit wrapping helpers for the
// barometric temperature and pressure compensation pipeline.
// No dependencies.
`default_nettype none
package bptc_pkg;

    // Field and datapath widths.
    localparam int unsigned RAW_W     = 20;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned FAHR_W    = 26;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned COEF_W    = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_NINE = 3'd3;

    // Compensation constants.
    localparam logic [31:0] K_PRESS_OFS  = 32'd64000;
    localparam logic [31:0] K_PRESS_FULL = 32'd1048576;
    localparam logic [31:0] K_PRESS_SCL  = 32'd3125;
    localparam logic [31:0] K_P1_BIAS    = 32'd32768;
    localparam logic [31:0] K_ROUND      = 32'd128;
    localparam logic [31:0] K_FAHR_OFS   = 32'd3200;

    // Reciprocals for exact unsigned division by 5 and by 100.
    localparam logic [31:0] RECIP_5    = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_5_SH = 34;
    localparam logic [31:0] RECIP_100  = 32'h51EB_851F;
    localparam int unsigned RECIP_100_SH = 37;

    // Arithmetic right shift of a 32-bit two's complement pattern.
    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
        logic signed [31:0] sv;
        sv = $signed(v);
        return 32'(sv >>> s);
    endfunction

    // Product wrapped to 32 bits.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        pr = a * b;
        return pr[31:0];
    endfunction

    // Sign-extended 16-bit coefficient.
    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/baro_temp_pressure_compensation.sv
// Barometric temperature and pressure compensation, 32-bit integer form.
// Pipeline: 10 arithmetic stages, a 32-stage divider and 4 post-division
// stages. Throughput: one transaction per cycle; the whole pipeline holds
// while the result is not taken.
// Reset (synchronous, active low) clears all valid bits and the coefficients.
`default_nettype none
module baro_temp_pressure_compensation (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bptc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bptc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [bptc_pkg::RAW_W-1:0]      i_raw_temperature,
    input  wire logic [bptc_pkg::RAW_W-1:0]      i_raw_pressure,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [bptc_pkg::WORD_W-1:0]   o_fine_temperature,
    output logic signed [bptc_pkg::WORD_W-1:0]   o_temp_centi_c,
    output logic signed [bptc_pkg::FAHR_W-1:0]   o_temp_fahrenheit,
    output logic [bptc_pkg::WORD_W-1:0]          o_pressure_pa
);
    import bptc_pkg::*;

    localparam int unsigned TAG_W = 2 * WORD_W + FAHR_W + 2;

    // Coefficient registers.
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_press_nine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal   <= '0;
            r_press_a    <= '0;
            r_press_b    <= '0;
            r_press_nine <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_CAL:   r_temp_cal   <= i_cfg_wdata[47:0];
                REG_PRESS_A:    r_press_a    <= i_cfg_wdata;
                REG_PRESS_B:    r_press_b    <= i_cfg_wdata;
                REG_PRESS_NINE: r_press_nine <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] c_t1, c_t2, c_t3, c_p1, c_p2, c_p3, c_p4;
    logic [31:0] c_p5, c_p6, c_p7, c_p8, c_p9;
    assign c_t1 = {16'b0, r_temp_cal[15:0]};
    assign c_t2 = sx16(r_temp_cal[31:16]);
    assign c_t3 = sx16(r_temp_cal[47:32]);
    assign c_p1 = {16'b0, r_press_a[15:0]};
    assign c_p2 = sx16(r_press_a[31:16]);
    assign c_p3 = sx16(r_press_a[47:32]);
    assign c_p4 = sx16(r_press_a[63:48]);
    assign c_p5 = sx16(r_press_b[15:0]);
    assign c_p6 = sx16(r_press_b[31:16]);
    assign c_p7 = sx16(r_press_b[47:32]);
    assign c_p8 = sx16(r_press_b[63:48]);
    assign c_p9 = sx16(r_press_nine);

    // Global advance: the pipeline moves whenever the output slot frees up.
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    logic [9:0] r_vld;
    logic [3:0] r_pv;

    // Front stage registers.
    logic [31:0] r1_x1, r1_d, r2_m1, r2_dd, r3_a, r3_m2, r4_fine;
    logic [31:0] r5_fine, r5_tc, r5_pa;
    logic [31:0] r6_fine, r6_tc, r6_sq, r6_ap5, r6_p2a, r6_tc9;
    logic [31:0] r7_fine, r7_tc, r7_m6, r7_m3, r7_ap5, r7_p2a, r7_q;
    logic        r7_qneg;
    logic [31:0] r8_fine, r8_tc, r8_b, r8_av, r8_smag;
    logic        r8_sneg;
    logic [31:0] r9_fine, r9_tc, r9_b, r9_a2;
    logic [FAHR_W-1:0] r9_f;
    logic [31:0] r10_fine, r10_tc, r10_den, r10_num;
    logic [FAHR_W-1:0] r10_f;
    logic [31:0] r_adcp [9];

    // Combinational helpers for the Fahrenheit path.
    logic [31:0] n7_mag, n7_q, n8_qs, n8_s, n8_smag, n9_fm, n9_fs;
    logic [63:0] n7_pr, n9_pr;
    always_comb begin
        n7_mag  = r6_tc9[31] ? (32'd0 - r6_tc9) : r6_tc9;
        n7_pr   = n7_mag * RECIP_5;
        n7_q    = 32'(n7_pr >> RECIP_5_SH);
        n8_qs   = r7_qneg ? (32'd0 - r7_q) : r7_q;
        n8_s    = n8_qs + K_FAHR_OFS;
        n8_smag = n8_s[31] ? (32'd0 - n8_s) : n8_s;
        n9_pr   = r8_smag * RECIP_100;
        n9_fm   = 32'(n9_pr >> RECIP_100_SH);
        n9_fs   = r8_sneg ? (32'd0 - n9_fm) : n9_fm;
    end

    // Valid bits for the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[8:0], i_in_valid};
        end
    end

    // Temperature and pressure front stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Stage 1: offsets against T1.
            r1_x1 <= ({12'b0, i_raw_temperature} >> 3) - {c_t1[30:0], 1'b0};
            r1_d  <= ({12'b0, i_raw_temperature} >> 4) - c_t1;
            r_adcp[0] <= {12'b0, i_raw_pressure};
            for (int k = 1; k < 9; k++) begin
                r_adcp[k] <= r_adcp[k-1];
            end
            // Stage 2: first products.
            r2_m1 <= mul32(r1_x1, c_t2);
            r2_dd <= mul32(r1_d, r1_d);
            // Stage 3: T3 term.
            r3_a  <= asr(r2_m1, 11);
            r3_m2 <= mul32(asr(r2_dd, 12), c_t3);
            // Stage 4: fine temperature.
            r4_fine <= r3_a + asr(r3_m2, 14);
            // Stage 5: centidegrees and pressure offset.
            r5_fine <= r4_fine;
            r5_tc   <= asr({r4_fine[29:0], 2'b0} + r4_fine + K_ROUND, 8);
            r5_pa   <= asr(r4_fine, 1) - K_PRESS_OFS;
            // Stage 6: pressure products on the offset.
            r6_fine <= r5_fine;
            r6_tc   <= r5_tc;
            r6_sq   <= mul32(asr(r5_pa, 2), asr(r5_pa, 2));
            r6_ap5  <= mul32(r5_pa, c_p5);
            r6_p2a  <= mul32(c_p2, r5_pa);
            r6_tc9  <= {r5_tc[28:0], 3'b0} + r5_tc;
            // Stage 7: square-term products, Fahrenheit divide by five.
            r7_fine <= r6_fine;
            r7_tc   <= r6_tc;
            r7_m6   <= mul32(asr(r6_sq, 11), c_p6);
            r7_m3   <= mul32(c_p3, asr(r6_sq, 13));
            r7_ap5  <= r6_ap5;
            r7_p2a  <= r6_p2a;
            r7_q    <= n7_q;
            r7_qneg <= r6_tc9[31];
            // Stage 8: offset sum and P1 factor.
            r8_fine <= r7_fine;
            r8_tc   <= r7_tc;
            r8_b    <= asr(r7_m6 + {r7_ap5[30:0], 1'b0}, 2) + {c_p4[15:0], 16'b0};
            r8_av   <= asr(asr(r7_m3, 3) + asr(r7_p2a, 1), 18);
            r8_smag <= n8_smag;
            r8_sneg <= n8_s[31];
            // Stage 9: divisor product, Fahrenheit divide by one hundred.
            r9_fine <= r8_fine;
            r9_tc   <= r8_tc;
            r9_b    <= r8_b;
            r9_a2   <= mul32(K_P1_BIAS + r8_av, c_p1);
            r9_f    <= n9_fs[FAHR_W-1:0];
            // Stage 10: divisor and scaled dividend.
            r10_fine <= r9_fine;
            r10_tc   <= r9_tc;
            r10_f    <= r9_f;
            r10_den  <= asr(r9_a2, 15);
            r10_num  <= mul32((K_PRESS_FULL - r_adcp[8]) - asr(r9_b, 12), K_PRESS_SCL);
        end
    end

    // Divider: a dividend below 2^31 is doubled first, otherwise the
    // quotient is doubled afterward.
    logic              w_big, w_zero;
    logic [31:0]       w_dividend;
    logic              w_dv_vld;
    logic [31:0]       w_quo;
    logic [TAG_W-1:0]  w_dv_tag;
    assign w_big      = r10_num[31];
    assign w_zero     = (r10_den == 32'd0);
    assign w_dividend = w_big ? r10_num : {r10_num[30:0], 1'b0};

    bptc_div #(
        .W     (WORD_W),
        .TAG_W (TAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_vld      (r_vld[9]),
        .i_dividend (w_dividend),
        .i_divisor  (r10_den),
        .i_tag      ({r10_fine, r10_tc, r10_f, w_zero, w_big}),
        .o_vld      (w_dv_vld),
        .o_quo      (w_quo),
        .o_tag      (w_dv_tag)
    );

    // Post-division stages.
    logic [31:0] rp1_p, rp2_p, rp2_sq3, rp2_pp8, rp3_p, rp3_m9, rp3_pp8;
    logic [31:0] rp_fine [3];
    logic [31:0] rp_tc   [3];
    logic [FAHR_W-1:0] rp_f [3];
    logic [2:0]  rp_zero;
    logic [31:0] r_o_fine, r_o_tc, r_o_p;
    logic [FAHR_W-1:0] r_o_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[2:0], w_dv_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Double the quotient of an undoubled dividend and clear on a zero divisor.
            rp1_p      <= w_dv_tag[1] ? 32'd0 :
                          (w_dv_tag[0] ? {w_quo[30:0], 1'b0} : w_quo);
            rp_zero[0] <= w_dv_tag[1];
            rp_fine[0] <= w_dv_tag[TAG_W-1 -: WORD_W];
            rp_tc[0]   <= w_dv_tag[FAHR_W+2 +: WORD_W];
            rp_f[0]    <= w_dv_tag[2 +: FAHR_W];
            // Correction products.
            rp2_p      <= rp1_p;
            rp2_sq3    <= mul32(rp1_p >> 3, rp1_p >> 3);
            rp2_pp8    <= mul32(rp1_p >> 2, c_p8);
            rp_zero[1] <= rp_zero[0];
            rp_fine[1] <= rp_fine[0];
            rp_tc[1]   <= rp_tc[0];
            rp_f[1]    <= rp_f[0];
            // P9 product.
            rp3_p      <= rp2_p;
            rp3_m9     <= mul32(c_p9, asr(rp2_sq3, 13));
            rp3_pp8    <= rp2_pp8;
            rp_zero[2] <= rp_zero[1];
            rp_fine[2] <= rp_fine[1];
            rp_tc[2]   <= rp_tc[1];
            rp_f[2]    <= rp_f[1];
            // Output register.
            r_o_p      <= rp_zero[2] ? 32'd0 :
                          rp3_p + asr(asr(rp3_m9, 12) + asr(rp3_pp8, 13) + c_p7, 4);
            r_o_fine   <= rp_fine[2];
            r_o_tc     <= rp_tc[2];
            r_o_f      <= rp_f[2];
        end
    end

    assign o_out_valid        = r_pv[3];
    assign o_fine_temperature = $signed(r_o_fine);
    assign o_temp_centi_c     = $signed(r_o_tc);
    assign o_temp_fahrenheit  = $signed(r_o_f);
    assign o_pressure_pa      = r_o_p;

    // A held pipeline keeps every valid bit in place.
    a_hold_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vld) && $stable(r_pv)))
        else $error("pipeline valid bits moved while stalled");

    // A result that is not taken stays with its data.
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_pressure_pa) && $stable(o_fine_temperature)))
        else $error("result dropped or changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && (r_vld == '0)))
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

FILE: rtl/bptc_div.sv
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// A tag travels with each operand pair. Depends on nothing else.
`default_nettype none
module bptc_div #(
    parameter int unsigned W     = 32,
    parameter int unsigned TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [W-1:0]     i_dividend,
    input  wire logic [W-1:0]     i_divisor,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_vld,
    output logic [W-1:0]          o_quo,
    output logic [TAG_W-1:0]      o_tag
);

    logic [W-1:0]     r_rem [W];
    logic [W-1:0]     r_dvd [W];
    logic [W-1:0]     r_quo [W];
    logic [W-1:0]     r_div [W];
    logic [TAG_W-1:0] r_tag [W];
    logic [W-1:0]     r_vld;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0]     rem_in, dvd_in, quo_in, div_in;
        logic [TAG_W-1:0] tag_in;
        logic             vld_in;
        logic [W:0]       n_tmp;
        logic             n_ge;
        logic [W:0]       n_diff;

        // Stage inputs come from the ports for the first stage.
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dvd_in = i_dividend;
            assign quo_in = '0;
            assign div_in = i_divisor;
            assign tag_in = i_tag;
            assign vld_in = i_vld;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dvd_in = r_dvd[k-1];
            assign quo_in = r_quo[k-1];
            assign div_in = r_div[k-1];
            assign tag_in = r_tag[k-1];
            assign vld_in = r_vld[k-1];
        end

        // Shift in the next dividend bit and try a subtract.
        always_comb begin
            n_tmp  = {rem_in, dvd_in[W-1]};
            n_ge   = n_tmp >= {1'b0, div_in};
            n_diff = n_tmp - {1'b0, div_in};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[W-1:0] : n_tmp[W-1:0];
                r_dvd[k] <= {dvd_in[W-2:0], 1'b0};
                r_quo[k] <= {quo_in[W-2:0], n_ge};
                r_div[k] <= div_in;
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_vld = r_vld[W-1];
    assign o_quo = r_quo[W-1];
    assign o_tag = r_tag[W-1];

endmodule
`default_nettype wire
